FILE: hdl/epoch_seconds_to_calendar_date_macros.svh
// Assertion macros used by the calendar date converter RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ECAL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ECAL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ECAL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ECAL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/ecal_pkg.sv
// Constants and calendar helper functions for the epoch to calendar date converter.
package ecal_pkg;

   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned BaseYear    = 1970;
   localparam int unsigned DaysPerYear = 365;

   // Field widths
   localparam int unsigned YearW   = 12;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned DayW    = 5;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;
   localparam int unsigned ZoneW   = 5;

   // Adjusted seconds fit in 33 bits; the shared subtractor works one bit wider
   localparam int unsigned AccW  = 33;
   localparam int unsigned DaysW = 17;

   // Register index of the zone offset
   localparam int unsigned RegZoneOffset = 0;

   // Gregorian leap rule; year/100 by reciprocal (exact below 4096)
   function automatic logic ecal_is_leap(input logic [YearW-1:0] y);
      logic [24:0]      prod;
      logic [5:0]       q100;
      logic [YearW-1:0] r100;
      begin
         prod = 25'(y) * 25'd5243;
         q100 = prod[24:19];
         r100 = y - (YearW'(q100) * YearW'(100));
         ecal_is_leap = (y[1:0] == 2'b00) && ((r100 != '0) || (q100[1:0] == 2'b00));
      end
   endfunction

   // Month length, month index 0 is January
   function automatic logic [DayW-1:0] ecal_month_len(input logic [3:0] m, input logic leap);
      begin
         case (m)
            4'd1: ecal_month_len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: ecal_month_len = 5'd30;
            default: ecal_month_len = 5'd31;
         endcase
      end
   endfunction

endpackage

FILE: hdl/epoch_seconds_to_calendar_date.sv
// Epoch seconds to calendar date converter: top level with shared subtract unit.
//
// Usage: a request on req_ (tdata = epoch seconds since 1970-01-01 UTC) is taken
// when req_tvalid and req_tready are high. The block adds the zone offset
// register (whole hours, signed, reset value 1), clamps a negative sum to zero
// and returns one response on rsp_ with year, month, day, hour, minute, second.
// The divisions and walks run through one 34-bit compare/subtract unit under
// a small sequencer: restoring division by the seconds per day, then by the
// seconds per hour and per minute, then a year walk (single years up to a
// leap-aligned year, then four-year blocks, then single years), a month walk
// and a final state that loads the output register. One request is in work at
// a time; req_tready is high only while the sequencer is idle, so a new request
// is taken only after the previous one has left the sequencer.
// A finished response sits in an output register, so the next request is
// taken while the receiver stalls; the sequencer then holds its next result
// until the output register frees up.
// Reset (synchronous, active high) clears the sequencer and the output valid
// and sets the zone offset to 1. Configure only while idle. Register 0 lies at
// byte address 0 of the APB port; pready is always high.
module epoch_seconds_to_calendar_date
   import ecal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                    // [25:21] hour, [31:26] minute, [37:32] second, [39:38] 0
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "epoch_seconds_to_calendar_date_macros.svh"

   // Sequencer states
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StDay   = 3'd1;
   localparam logic [2:0] StHour  = 3'd2;
   localparam logic [2:0] StMin   = 3'd3;
   localparam logic [2:0] StYear  = 3'd4;
   localparam logic [2:0] StMonth = 3'd5;
   localparam logic [2:0] StDone  = 3'd6;

   localparam logic [AccW:0] DayOp   = (AccW+1)'(SecsPerDay);
   localparam logic [AccW:0] HourOp  = (AccW+1)'(SecsPerHour);
   localparam logic [AccW:0] MinOp   = (AccW+1)'(SecsPerMin);
   localparam logic [AccW:0] YearOp  = (AccW+1)'(DaysPerYear);
   localparam logic [AccW:0] BlockOp = (AccW+1)'(4 * DaysPerYear);

   logic [2:0]               state_ff, state_in;
   logic [4:0]               k_ff, k_in;
   logic [AccW-1:0]          acc_ff, acc_in;
   logic [DaysW-1:0]         days_ff, days_in;
   logic [HourW-1:0]         hour_ff, hour_in;
   logic [MinuteW-1:0]       minute_ff, minute_in;
   logic [SecondW-1:0]       second_ff, second_in;
   logic [YearW-1:0]         year_ff, year_in;
   logic [3:0]               mon_ff, mon_in;
   logic                     fine_ff, fine_in;
   logic signed [ZoneW-1:0]  zone_ff;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]              rsp_tdata_ff, rsp_tdata_in;

   logic                     req_fire;
   logic                     out_free;
   logic                     leap;
   logic                     block_mode;
   logic [AccW:0]            operand;
   logic [AccW:0]            diff;
   logic                     borrow;
   logic signed [AccW:0]     adj_sum;
   logic                     csr_wr;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign leap       = ecal_is_leap(year_ff);
   assign block_mode = (year_ff[1:0] == 2'b00) && !fine_ff;

   // Zone-adjusted count, sign extended so the sum can go negative
   assign adj_sum = $signed({2'b00, req_tdata})
                  + ((AccW+1)'(zone_ff) * $signed((AccW+1)'(SecsPerHour)));

   // Shared compare/subtract unit operand
   always_comb begin
      case (state_ff)
         StDay:   operand = DayOp << k_ff;
         StHour:  operand = HourOp << k_ff;
         StMin:   operand = MinOp << k_ff;
         StYear:  operand = (block_mode ? BlockOp : YearOp) + (AccW+1)'(leap);
         StMonth: operand = (AccW+1)'(ecal_month_len(mon_ff, leap));
         default: operand = '0;
      endcase
   end

   assign diff   = {1'b0, acc_ff} - operand;
   assign borrow = diff[AccW];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      days_in       = days_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      year_in       = year_ff;
      mon_in        = mon_ff;
      fine_in       = fine_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               acc_in    = adj_sum[AccW] ? '0 : adj_sum[AccW-1:0];
               k_in      = 5'(DaysW - 1);
               days_in   = '0;
               hour_in   = '0;
               minute_in = '0;
               fine_in   = 1'b0;
               state_in  = StDay;
            end
         end
         StDay: begin
            if (!borrow) begin
               acc_in  = diff[AccW-1:0];
               days_in = days_ff | (DaysW'(1) << k_ff);
            end
            if (k_ff == '0) begin
               k_in     = 5'(HourW - 1);
               state_in = StHour;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         StHour: begin
            if (!borrow) begin
               acc_in  = diff[AccW-1:0];
               hour_in = hour_ff | (HourW'(1) << k_ff);
            end
            if (k_ff == '0) begin
               k_in     = 5'(MinuteW - 1);
               state_in = StMin;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         StMin: begin
            if (!borrow) begin
               acc_in    = diff[AccW-1:0];
               minute_in = minute_ff | (MinuteW'(1) << k_ff);
            end
            if (k_ff == '0) begin
               // what is left is the second; switch over to the day count
               second_in = borrow ? acc_ff[SecondW-1:0] : diff[SecondW-1:0];
               acc_in    = AccW'(days_in);
               year_in   = YearW'(BaseYear);
               state_in  = StYear;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         StYear: begin
            if (!borrow) begin
               acc_in  = diff[AccW-1:0];
               year_in = year_ff + (block_mode ? YearW'(4) : YearW'(1));
            end else if (block_mode) begin
               // fewer than four years left: walk single years
               fine_in = 1'b1;
            end else begin
               mon_in   = '0;
               state_in = StMonth;
            end
         end
         StMonth: begin
            if ((mon_ff == 4'd11) || borrow) begin
               state_in = StDone;
            end else begin
               acc_in = diff[AccW-1:0];
               mon_in = mon_ff + 4'd1;
            end
         end
         StDone: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, second_ff, minute_ff, hour_ff,
                                acc_ff[DayW-1:0] + DayW'(1), mon_ff + 4'd1, year_ff};
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      days_ff      <= days_in;
      hour_ff      <= hour_in;
      minute_ff    <= minute_in;
      second_ff    <= second_in;
      year_ff      <= year_in;
      mon_ff       <= mon_in;
      fine_ff      <= fine_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZoneW'(1);
      end else if (csr_wr && (csr_paddr[2] == 1'(RegZoneOffset))) begin
         zone_ff <= csr_pwdata[ZoneW-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == 1'(RegZoneOffset)) ? 32'(zone_ff) : '0;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   `ECAL_ASSERT_NXT(a_accept_starts, clock, reset, req_fire, state_ff == StDay, "accept did not start division")
   `ECAL_ASSERT_IMP(a_tod_range, clock, reset, state_ff == StHour, acc_ff < AccW'(SecsPerDay), "time of day out of range")
   `ECAL_ASSERT_IMP(a_doy_range, clock, reset, state_ff == StMonth, acc_ff < AccW'(366), "day of year out of range")
   `ECAL_ASSERT_NXT(a_rsp_loaded, clock, reset, (state_ff == StDone) && out_free, rsp_tvalid, "result not presented")

endmodule

FILE: verif/tb_epoch_seconds_to_calendar_date.sv
// Testbench for the epoch seconds to calendar date converter: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_date
   import ecal_pkg::*;
();

   localparam logic [2:0] ZoneOffsetAddr = 3'(4 * RegZoneOffset);
   localparam int unsigned MaxGap = 11;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned PhaseItems = 190;

   typedef struct {
      bit [YearW-1:0]   year;
      bit [MonthW-1:0]  month;
      bit [DayW-1:0]    day;
      bit [HourW-1:0]   hour;
      bit [MinuteW-1:0] minute;
      bit [SecondW-1:0] second;
   } cal_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] epoch_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [11:0] year, [15:12] month, [20:16] day_of_month,
                                   // [25:21] hour, [31:26] minute, [37:32] second
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Requests waiting to be sent, and dates still owed by the block
   bit [31:0]        pending_secs[$];
   cal_date_type     expected_dates[$];
   bit signed [4:0]  zone_hours;
   int unsigned      mismatch_count = 0;
   int unsigned      send_gap = 0;
   bit               send_burst = 1'b0;
   int unsigned      recv_stall = 0;
   bit               recv_burst = 1'b0;
   int unsigned      hold_asks = 0;
   int unsigned      hold_seen = 0;
   int unsigned      hold_left = 0;

   epoch_seconds_to_calendar_date DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Gregorian rule: every 4th year, but not centuries unless divisible by 400
   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   // Days in month, 0 is January
   function automatic int unsigned month_days(input int unsigned mon, input bit leap);
      case (mon)
         1: return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default: return 31;
      endcase
   endfunction

   // Expected calendar date for a count of seconds under the given zone offset
   function automatic cal_date_type calc_calendar_date(input bit [31:0] secs,
                                                       input bit signed [4:0] zone);
      longint       adj;
      longint       day_cnt;
      int unsigned  tod;
      int unsigned  yr;
      int unsigned  mon;
      cal_date_type d;
      adj = longint'(secs) + longint'(zone) * longint'(SecsPerHour);
      if (adj < 0) adj = 0;
      day_cnt = adj / longint'(SecsPerDay);
      tod = int'(adj % longint'(SecsPerDay));
      yr = BaseYear;
      while (day_cnt >= (is_leap_year(yr) ? 366 : 365)) begin
         day_cnt -= is_leap_year(yr) ? 366 : 365;
         yr++;
      end
      mon = 0;
      while (mon < 11 && day_cnt >= month_days(mon, is_leap_year(yr))) begin
         day_cnt -= month_days(mon, is_leap_year(yr));
         mon++;
      end
      d.year   = YearW'(yr);
      d.month  = MonthW'(mon + 1);
      d.day    = DayW'(day_cnt + 1);
      d.hour   = HourW'(tod / SecsPerHour);
      d.minute = MinuteW'((tod % SecsPerHour) / SecsPerMin);
      d.second = SecondW'(tod % SecsPerMin);
      return d;
   endfunction

   // Random request: uniform, near year/month starts, near midnight, tiny, or near the top
   function automatic bit [31:0] pick_epoch();
      longint      val;
      int unsigned yr;
      int unsigned mon;
      case ($urandom_range(0, 5))
         0, 1: val = $urandom;
         2: begin
            yr = $urandom_range(BaseYear, 2105);
            mon = $urandom_range(0, 11);
            val = 0;
            for (int unsigned y = BaseYear; y < yr; y++) val += is_leap_year(y) ? 366 : 365;
            for (int unsigned m = 0; m < mon; m++) val += month_days(m, is_leap_year(yr));
            val = val * SecsPerDay + $urandom_range(0, 4 * SecsPerDay) - 2 * SecsPerDay;
         end
         3: val = $urandom_range(0, 60000);
         4: val = 32'hFFFF_FFFF - $urandom_range(0, 200000);
         default: val = longint'($urandom_range(0, 49000)) * SecsPerDay
                        + $urandom_range(0, 7200) - 3600;
      endcase
      if (val < 0) val = 0;
      if (val > 32'hFFFF_FFFF) val = 32'hFFFF_FFFF;
      return 32'(val);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Shadow of the zone offset register, updated on the APB write handshake
   always @(posedge clock) begin
      if (reset) begin
         zone_hours <= 5'sd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == ZoneOffsetAddr) begin
         zone_hours <= csr_pwdata[ZoneW-1:0];
      end
   end

   // Request driver: predicts on acceptance, then idles a random gap
   always @(posedge clock) begin : drive_requests
      bit busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(calc_calendar_date(req_tdata, zone_hours));
            busy = 1'b0;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, MaxGap);
         end
         if (!busy) begin
            if (send_gap == 0 && pending_secs.size() != 0) begin
               req_tdata  <= pending_secs.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
               if (send_gap != 0) send_gap--;
            end
         end
      end
   end

   // Response monitor: compares each date with the oldest prediction, stalls at random
   always @(posedge clock) begin : watch_responses
      cal_date_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("unexpected response 0x%010h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("year",         want.year,   rsp_tdata[11:0]);
               check_field("month",        want.month,  rsp_tdata[15:12]);
               check_field("day_of_month", want.day,    rsp_tdata[20:16]);
               check_field("hour",         want.hour,   rsp_tdata[25:21]);
               check_field("minute",       want.minute, rsp_tdata[31:26]);
               check_field("second",       want.second, rsp_tdata[37:32]);
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, MaxGap);
         end
         // long back-pressure when asked
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_stall != 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // APB write of the zone offset; setup then access phase
   task automatic write_zone(input bit signed [4:0] hrs);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ZoneOffsetAddr;
      csr_pwdata  <= {{27{hrs[4]}}, hrs};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every request is sent and every date has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_secs.size() != 0 || req_tvalid || expected_dates.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) pending_secs.push_back(pick_epoch());
   endtask

   initial begin : run_phases
      bit signed [4:0] zone_list[8];
      zone_list = '{-5'sd12, 5'sd14, 5'sd0, 5'sd7, -5'sd5, -5'sd1, 5'sd0, 5'sd0};
      zone_list[6] = 5'($urandom_range(0, 31));
      zone_list[7] = 5'($urandom_range(0, 31));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes and leap/century boundaries at the reset offset
      pending_secs = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'd68169600, 32'd68083199,
                       32'd94694399, 32'd951782399, 32'd951868799, 32'd978307199,
                       32'd4107542399, 32'd4102444799, 32'd82799, 32'd86399};
      wait_idle();

      // Most negative offset: clamp to the epoch start
      write_zone(-5'sd16);
      pending_secs = '{32'd0, 32'd57599, 32'd57600, 32'd57601, 32'hFFFF_FFFF};
      wait_idle();

      // Largest offset on the largest count stays inside 2106
      write_zone(5'sd15);
      pending_secs = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'd0};
      wait_idle();

      // Random phases across several offsets
      foreach (zone_list[i]) begin
         write_zone(zone_list[i]);
         if (i == 1) begin
            // sender pauses mid-phase until the block has fully drained
            queue_random(PhaseItems / 2);
            wait_idle();
            queue_random(PhaseItems - PhaseItems / 2);
         end else begin
            queue_random(PhaseItems);
         end
         // receiver holds off while requests keep coming, so the input stalls
         if (i == 0 || i == 4) hold_asks++;
         wait_idle();
      end

      repeat (100) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
